@@ sv/k1df_pkg.sv @@
// k1df_pkg: shared types and codes of the scalar fixed-point filter
// sequencer states, configuration register indexes, command and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package k1df_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int STAT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COEF       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBS_COEF         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ESTIMATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COVARIANCE = 3'd5;

  localparam logic CMD_FILTER  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZDEN = 2'd2;

  // one state per product of the update, one for the gain division, plus idle and finish
  typedef enum logic [3:0] {
    S_IDLE,
    S_XP,
    S_AA,
    S_PP,
    S_PH,
    S_DEN,
    S_DIV,
    S_INN,
    S_XN,
    S_KH,
    S_PN,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

@@ sv/kalman_1d_filter.sv @@
// kalman_1d_filter: scalar fixed-point state estimator with one shared
// chunked multiplier and a bit-serial divider under a small sequencer
// depends on k1df_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_cmd, in_measurement
// out       output     out_valid / out_stall  out_estimate, out_gain, out_covariance, out_status
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// a measurement runs the nine multiplies on the shared multiplier, whose chunk
// count is NCH = ceil((DATA_WIDTH+1)/16), and the 1 bit per cycle gain divider;
// a nonpositive denominator skips the division and the update, and a restart
// goes straight to the result with the start estimate and covariance
// in_stall stays high until the result is loaded, which waits on a held result
// reset is synchronous, loads the configuration defaults and the start state
module kalman_1d_filter #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_cmd,
  input  wire signed [DATA_WIDTH-1:0]       in_measurement,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_estimate,
  output logic signed [DATA_WIDTH-1:0]      out_gain,
  output logic        [DATA_WIDTH-1:0]      out_covariance,
  output logic [k1df_pkg::STAT_W-1:0]       out_status,
  input  wire                               cfg_we,
  input  wire  [k1df_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [DATA_WIDTH-1:0]             cfg_data
);

  localparam int W     = DATA_WIDTH;
  localparam int IW    = W + 2;            // intermediates span [-2^W, 2^W-1]
  localparam int SW    = W + 3;            // sums of two intermediates
  localparam int MW    = W + 1;            // magnitude of an intermediate
  localparam int MB    = 16;               // multiplier chunk
  localparam int NCH   = (MW + MB - 1) / MB;
  localparam int MBW   = NCH * MB;
  localparam int AW    = 2 * MW;
  localparam int NBITS = MW + FRAC_BITS;   // dividend bits of the gain
  localparam int MAGW  = (AW > NBITS) ? AW : NBITS;
  localparam int CW    = $clog2(NBITS + 2);

  localparam longint unsigned ONE_L  = 64'd1 << FRAC_BITS;
  localparam longint unsigned QRST_L = (ONE_L * 64'd2 + 64'd500) / 64'd1000;
  localparam longint unsigned RRST_L = (ONE_L + 64'd5) / 64'd10;

  localparam logic [IW-1:0] LIM_NEG = IW'(0) - (IW'(1) << W);
  localparam logic [IW-1:0] LIM_M1  = (IW'(1) << W) - IW'(1);
  localparam logic [SW-1:0] ONE_S   = SW'(ONE_L);

  // magnitude to clamped signed intermediate, saturation flag on top
  function automatic logic [IW:0] sat_mag(input logic [MAGW-1:0] m, input logic ng);
    logic [MAGW-1:0] lim;
    logic [IW-1:0]   r;
    logic            s;
    lim = MAGW'(1) << W;
    s   = 1'b0;
    if (ng) begin
      if (m > lim) begin
        r = LIM_NEG;
        s = 1'b1;
      end else begin
        r = IW'(0) - m[IW-1:0];
      end
    end else begin
      if (m >= lim) begin
        r = LIM_M1;
        s = 1'b1;
      end else begin
        r = m[IW-1:0];
      end
    end
    return {s, r};
  endfunction

  function automatic logic [IW:0] clamp_sum(input logic [SW-1:0] v);
    logic [IW-1:0] r;
    logic          s;
    s = 1'b0;
    if ((&v[SW-1:W]) || !(|v[SW-1:W])) begin
      r = v[IW-1:0];
    end else if (v[SW-1]) begin
      r = LIM_NEG;
      s = 1'b1;
    end else begin
      r = LIM_M1;
      s = 1'b1;
    end
    return {s, r};
  endfunction

  // final clamp to the signed output range
  function automatic logic [W:0] fit_signed(input logic [IW-1:0] v);
    logic [W-1:0] r;
    logic         s;
    s = 1'b0;
    if ((&v[IW-1:W-1]) || !(|v[IW-1:W-1])) begin
      r = v[W-1:0];
    end else begin
      r = {v[IW-1], {(W-1){~v[IW-1]}}};
      s = 1'b1;
    end
    return {s, r};
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic [IW-1:0] v);
    logic [IW-1:0] t;
    t = v[IW-1] ? (IW'(0) - v) : v;
    return t[MW-1:0];
  endfunction

  function automatic logic [SW-1:0] sx(input logic [IW-1:0] v);
    return {{(SW-IW){v[IW-1]}}, v};
  endfunction

  // registers
  k1df_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             sat_r, sat_nxt;
  logic             zden_r, zden_nxt;
  logic [W-1:0]     a_r, a_nxt, h_r, h_nxt, q_r, q_nxt, r_r, r_nxt;
  logic [W-1:0]     x0_r, x0_nxt, p0_r, p0_nxt;
  logic [W-1:0]     est_r, est_nxt, cov_r, cov_nxt;
  logic [W-1:0]     z_r, z_nxt;
  logic [IW-1:0]    xp_r, xp_nxt, pp_r, pp_nxt, ph_r, ph_nxt;
  logic [IW-1:0]    den_r, den_nxt, k_r, k_nxt, tmp_r, tmp_nxt;
  logic             neg_r, neg_nxt;
  logic [MW-1:0]    ma_r, ma_nxt;
  logic [MBW-1:0]   mb_r, mb_nxt;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic [NBITS-1:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     oest_r, oest_nxt, ogain_r, ogain_nxt, ocov_r, ocov_nxt;
  logic [k1df_pkg::STAT_W-1:0] ostat_r, ostat_nxt;

  // datapath
  logic [IW-1:0]    opa, opb;
  logic             mul_st, mul_done;
  logic [MW+MB-1:0] mprod;
  logic [IW-1:0]    mres, dres, cval;
  logic             msat, dsat, csat;
  logic [SW-1:0]    csum;
  logic [W:0]       trial;
  logic [W:0]       fx, fk;
  logic [W-1:0]     fcov;
  logic             fcsat;
  logic [IW-1:0]    a_ext, h_ext, x_ext, p_ext;

  assign a_ext = {{(IW-W){a_r[W-1]}}, a_r};
  assign h_ext = {{(IW-W){h_r[W-1]}}, h_r};
  assign x_ext = {{(IW-W){est_r[W-1]}}, est_r};
  assign p_ext = {{(IW-W){1'b0}}, cov_r};

  assign mprod = ma_r * mb_r[MBW-1 -: MB];
  assign {msat, mres} = sat_mag(MAGW'(acc_r >> FRAC_BITS), neg_r);
  assign {dsat, dres} = sat_mag(MAGW'(quo_r), neg_r);
  assign {csat, cval} = clamp_sum(csum);
  assign trial = {rem_r, dvd_r[NBITS-1]};

  assign fx = fit_signed(xp_r);
  assign fk = fit_signed(k_r);

  always_comb begin
    if (pp_r[IW-1]) begin
      fcov  = '0;
      fcsat = 1'b1;
    end else if (pp_r[W]) begin
      fcov  = '1;
      fcsat = 1'b1;
    end else begin
      fcov  = pp_r[W-1:0];
      fcsat = 1'b0;
    end
  end

  assign in_stall       = (state_r != k1df_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_estimate   = oest_r;
  assign out_gain       = ogain_r;
  assign out_covariance = ocov_r;
  assign out_status     = ostat_r;

  // operand routing for the shared multiplier and the post-add
  always_comb begin
    mul_st = 1'b1;
    opa    = '0;
    opb    = '0;
    csum   = '0;
    case (state_r)
      k1df_pkg::S_XP: begin
        opa = a_ext;
        opb = x_ext;
      end
      k1df_pkg::S_AA: begin
        opa = a_ext;
        opb = a_ext;
      end
      k1df_pkg::S_PP: begin
        opa  = tmp_r;
        opb  = p_ext;
        csum = sx(mres) + {{(SW-W){1'b0}}, q_r};
      end
      k1df_pkg::S_PH: begin
        opa = pp_r;
        opb = h_ext;
      end
      k1df_pkg::S_DEN: begin
        opa  = ph_r;
        opb  = h_ext;
        csum = sx(mres) + {{(SW-W){1'b0}}, r_r};
      end
      k1df_pkg::S_INN: begin
        opa  = h_ext;
        opb  = xp_r;
        csum = {{(SW-W){z_r[W-1]}}, z_r} - sx(mres);
      end
      k1df_pkg::S_XN: begin
        opa  = k_r;
        opb  = tmp_r;
        csum = sx(xp_r) + sx(mres);
      end
      k1df_pkg::S_KH: begin
        opa  = k_r;
        opb  = h_ext;
        csum = ONE_S - sx(mres);
      end
      k1df_pkg::S_PN: begin
        opa = tmp_r;
        opb = pp_r;
      end
      default: mul_st = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    sat_nxt       = sat_r;
    zden_nxt      = zden_r;
    a_nxt         = a_r;
    h_nxt         = h_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    x0_nxt        = x0_r;
    p0_nxt        = p0_r;
    est_nxt       = est_r;
    cov_nxt       = cov_r;
    z_nxt         = z_r;
    xp_nxt        = xp_r;
    pp_nxt        = pp_r;
    ph_nxt        = ph_r;
    den_nxt       = den_r;
    k_nxt         = k_r;
    tmp_nxt       = tmp_r;
    neg_nxt       = neg_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    acc_nxt       = acc_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    oest_nxt      = oest_r;
    ogain_nxt     = ogain_r;
    ocov_nxt      = ocov_r;
    ostat_nxt     = ostat_r;
    mul_done      = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        k1df_pkg::CFG_STATE_COEF:       a_nxt  = cfg_data;
        k1df_pkg::CFG_OBS_COEF:         h_nxt  = cfg_data;
        k1df_pkg::CFG_PROCESS_NOISE:    q_nxt  = cfg_data;
        k1df_pkg::CFG_MEASURE_NOISE:    r_nxt  = cfg_data;
        k1df_pkg::CFG_START_ESTIMATE:   x0_nxt = cfg_data;
        k1df_pkg::CFG_START_COVARIANCE: p0_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // shared multiplier: load magnitudes, then one chunk of b per cycle
    if (mul_st) begin
      if (cnt_r == '0) begin
        neg_nxt = opa[IW-1] ^ opb[IW-1];
        ma_nxt  = mag_of(opa);
        mb_nxt  = MBW'(mag_of(opb));
        acc_nxt = '0;
        cnt_nxt = CW'(1);
      end else if (cnt_r != CW'(NCH + 1)) begin
        acc_nxt = (acc_r << MB) + AW'(mprod);
        mb_nxt  = mb_r << MB;
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        cnt_nxt  = '0;
        mul_done = 1'b1;
      end
    end

    case (state_r)
      k1df_pkg::S_IDLE: begin
        if (in_valid) begin
          z_nxt    = in_measurement;
          sat_nxt  = 1'b0;
          zden_nxt = 1'b0;
          cnt_nxt  = '0;
          if (in_cmd == k1df_pkg::CMD_RESTART) begin
            xp_nxt    = {{(IW-W){x0_r[W-1]}}, x0_r};
            k_nxt     = '0;
            pp_nxt    = {{(IW-W){1'b0}}, p0_r};
            state_nxt = k1df_pkg::S_FIN;
          end else begin
            state_nxt = k1df_pkg::S_XP;
          end
        end
      end
      k1df_pkg::S_XP: begin
        if (mul_done) begin
          xp_nxt    = mres;
          sat_nxt   = sat_r | msat;
          state_nxt = k1df_pkg::S_AA;
        end
      end
      k1df_pkg::S_AA: begin
        if (mul_done) begin
          tmp_nxt   = mres;
          sat_nxt   = sat_r | msat;
          state_nxt = k1df_pkg::S_PP;
        end
      end
      k1df_pkg::S_PP: begin
        if (mul_done) begin
          pp_nxt    = cval;
          sat_nxt   = sat_r | msat | csat;
          state_nxt = k1df_pkg::S_PH;
        end
      end
      k1df_pkg::S_PH: begin
        if (mul_done) begin
          ph_nxt    = mres;
          sat_nxt   = sat_r | msat;
          state_nxt = k1df_pkg::S_DEN;
        end
      end
      k1df_pkg::S_DEN: begin
        if (mul_done) begin
          den_nxt = cval;
          sat_nxt = sat_r | msat | csat;
          // nonpositive denominator: keep the prediction, gain zero
          if (cval[IW-1] || (cval == '0)) begin
            k_nxt     = '0;
            zden_nxt  = 1'b1;
            state_nxt = k1df_pkg::S_FIN;
          end else begin
            state_nxt = k1df_pkg::S_DIV;
          end
        end
      end
      k1df_pkg::S_DIV: begin
        if (cnt_r == '0) begin
          neg_nxt = ph_r[IW-1];
          dvd_nxt = {mag_of(ph_r), {FRAC_BITS{1'b0}}};
          rem_nxt = '0;
          quo_nxt = '0;
          cnt_nxt = CW'(1);
        end else if (cnt_r != CW'(NBITS + 1)) begin
          // restoring division, one quotient bit per cycle
          if (trial >= {1'b0, den_r[W-1:0]}) begin
            rem_nxt = W'(trial - {1'b0, den_r[W-1:0]});
            quo_nxt = {quo_r[NBITS-2:0], 1'b1};
          end else begin
            rem_nxt = trial[W-1:0];
            quo_nxt = {quo_r[NBITS-2:0], 1'b0};
          end
          dvd_nxt = dvd_r << 1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          k_nxt     = dres;
          sat_nxt   = sat_r | dsat;
          cnt_nxt   = '0;
          state_nxt = k1df_pkg::S_INN;
        end
      end
      k1df_pkg::S_INN: begin
        if (mul_done) begin
          tmp_nxt   = cval;
          sat_nxt   = sat_r | msat | csat;
          state_nxt = k1df_pkg::S_XN;
        end
      end
      k1df_pkg::S_XN: begin
        if (mul_done) begin
          xp_nxt    = cval;
          sat_nxt   = sat_r | msat | csat;
          state_nxt = k1df_pkg::S_KH;
        end
      end
      k1df_pkg::S_KH: begin
        if (mul_done) begin
          tmp_nxt   = cval;
          sat_nxt   = sat_r | msat | csat;
          state_nxt = k1df_pkg::S_PN;
        end
      end
      k1df_pkg::S_PN: begin
        if (mul_done) begin
          pp_nxt    = mres;
          sat_nxt   = sat_r | msat;
          state_nxt = k1df_pkg::S_FIN;
        end
      end
      k1df_pkg::S_FIN: begin
        // wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          oest_nxt      = fx[W-1:0];
          ogain_nxt     = fk[W-1:0];
          ocov_nxt      = fcov;
          est_nxt       = fx[W-1:0];
          cov_nxt       = fcov;
          out_valid_nxt = 1'b1;
          state_nxt     = k1df_pkg::S_IDLE;
          if (zden_r) begin
            ostat_nxt = k1df_pkg::STAT_ZDEN;
          end else if (sat_r || fx[W] || fk[W] || fcsat) begin
            ostat_nxt = k1df_pkg::STAT_SAT;
          end else begin
            ostat_nxt = k1df_pkg::STAT_OK;
          end
        end
      end
      default: state_nxt = k1df_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= k1df_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      zden_r      <= 1'b0;
      a_r         <= W'(ONE_L);
      h_r         <= W'(ONE_L);
      q_r         <= W'(QRST_L);
      r_r         <= W'(RRST_L);
      x0_r        <= '0;
      p0_r        <= W'(ONE_L);
      est_r       <= '0;
      cov_r       <= W'(ONE_L);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sat_r       <= sat_nxt;
      zden_r      <= zden_nxt;
      a_r         <= a_nxt;
      h_r         <= h_nxt;
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      x0_r        <= x0_nxt;
      p0_r        <= p0_nxt;
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r     <= z_nxt;
    xp_r    <= xp_nxt;
    pp_r    <= pp_nxt;
    ph_r    <= ph_nxt;
    den_r   <= den_nxt;
    k_r     <= k_nxt;
    tmp_r   <= tmp_nxt;
    neg_r   <= neg_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    acc_r   <= acc_nxt;
    dvd_r   <= dvd_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    oest_r  <= oest_nxt;
    ogain_r <= ogain_nxt;
    ocov_r  <= ocov_nxt;
    ostat_r <= ostat_nxt;
  end

endmodule

`default_nettype wire
